>>> hw/rtl/bbd_pkg.sv
// Shared types and constants for the 3x3 box blur and downscale block.
package bbd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_BLUR_ENABLE     = 2'd2;
    localparam logic [1:0] REG_DECIMATE_ENABLE = 2'd3;

    // Register widths and reset values.
    localparam int          WIDTH_BITS      = 12;
    localparam int          HEIGHT_BITS     = 13;
    localparam int          CFG_DATA_BITS   = 13;
    localparam logic [11:0] WIDTH_RESET     = 12'd2048;
    localparam logic [12:0] HEIGHT_RESET    = 13'd1024;
    localparam logic [12:0] HEIGHT_MAX      = 13'd4096;
    localparam logic [11:0] WIDTH_FIELD_MAX = 12'd4095;

    // Window selection codes: row or column 0, 1 or 2 of the 3x3 window.
    localparam logic [1:0] SEL_0 = 2'd0;
    localparam logic [1:0] SEL_1 = 2'd1;
    localparam logic [1:0] SEL_2 = 2'd2;

    // Results that one pixel can cause.
    localparam int SLOTS = 4;

    // floor(x / 9) == (x * DIV9_RECIP) >> 16 for every 3x3 sum of 8-bit pixels.
    localparam logic [12:0] DIV9_RECIP = 13'd7282;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 32;
    localparam int PTR_W      = 5;
    localparam int CNT_W      = 6;
    localparam int CRED_W     = 7;

    // One result as it leaves the block.
    typedef struct packed {
        logic [7:0]  pixel;
        logic [10:0] col;
        logic [11:0] row;
        logic        last;
    } result_t;

    // Where one result lies and how its window is gathered.
    typedef struct packed {
        logic            keep;
        logic [2:0][1:0] rsel;
        logic [2:0][1:0] csel;
        logic [10:0]     col;
        logic [11:0]     row;
        logic            last;
    } slot_meta_t;

    // A pixel together with its two line store reads, headed for the window.
    typedef struct packed {
        logic                   valid;
        logic [7:0]             pixel;
        logic [7:0]             up;
        logic [7:0]             mid;
        slot_meta_t [SLOTS-1:0] meta;
    } win_in_t;

    // Occupancy of the window pipeline.
    typedef struct packed {
        logic b_valid;
        logic c_valid;
    } pipe_status_t;

endpackage

>>> hw/rtl/box_blur_3x3_downscale.sv
// Top level of the streaming 3x3 box blur with optional 2x decimation.
//
// Pixels enter in raster order on in_valid / in_stall / pixel_in; a request is
// taken at a rising edge with in_valid high and in_stall low. Results leave on
// out_valid / out_stall with pixel_out, out_col, out_row and frame_last.
// Configuration is written through cfg_write / cfg_index / cfg_data while the
// block is idle; writing the width or height restarts the frame.
// With the result queue empty, out_valid rises once the pixel completing a window
// has passed the a1 read stage, the window and b stage, the c stage and the queue.
// One pixel per clock is taken on every row but the last while out_stall is low;
// on the last row each pixel releases up to four results, so the single output
// port sets the rate there. The line store is one memory with one
// read and one write port, read when a pixel is taken and written back the
// next cycle, with forwarding when both touch the same column.
// A 32-entry result queue decouples the output; when the receiver stalls,
// the queue fills and in_stall rises once it cannot hold four more results
// for every pixel in flight and for the next one.
// Reset restores the register defaults, clears the counters, the window and
// the queue. The line store is not cleared and needs no clearing pass.
module box_blur_3x3_downscale
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               pixel_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               pixel_out,
    output logic [10:0]              out_col,
    output logic [11:0]              out_row,
    output logic                     frame_last,
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int          ADDR_W    = $clog2(MAX_WIDTH);
    localparam logic [11:0] WIDTH_CAP = (MAX_WIDTH > 4095) ? WIDTH_FIELD_MAX
                                                           : 12'(MAX_WIDTH);
    localparam int          COL_W     = $clog2(int'(WIDTH_CAP));

    // Configuration registers.
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic                   blur_reg;
    logic                   decim_reg;

    // Position counters.
    logic [COL_W-1:0] col_count_reg;
    logic [COL_W-1:0] col_count_next;
    logic [11:0]      row_count_reg;
    logic [11:0]      row_count_next;

    // First pipeline stage: line store read in flight.
    logic                   a1_valid_reg;
    logic [7:0]             a1_pixel_reg;
    logic [ADDR_W-1:0]      a1_addr_reg;
    logic                   a1_fwd_reg;
    logic [15:0]            a1_fwd_data_reg;
    slot_meta_t [SLOTS-1:0] a1_meta_reg;

    logic                   accept;
    logic                   pop;
    logic                   dims_write;
    logic [11:0]            eff_width;
    logic [12:0]            eff_height;
    logic                   last_col;
    logic                   last_row;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   fwd_hit;
    logic [15:0]            mem_rd_data;
    logic [15:0]            line_word;
    logic [15:0]            line_wr_data;
    slot_meta_t [SLOTS-1:0] meta_now;
    win_in_t                win_in;
    logic [SLOTS-1:0]       push_valid;
    result_t [SLOTS-1:0]    push_data;
    pipe_status_t           status;
    result_t                head;
    logic [CNT_W-1:0]       fifo_count;
    logic [2:0]             inflight;
    logic [CRED_W-1:0]      credit_used;

    // Effective frame size after clamping.
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = 12'd1;
        end
        else if (width_reg > WIDTH_CAP)
        begin
            eff_width = WIDTH_CAP;
        end
        else
        begin
            eff_width = width_reg;
        end

        if (height_reg == '0)
        begin
            eff_height = 13'd1;
        end
        else if (height_reg > HEIGHT_MAX)
        begin
            eff_height = HEIGHT_MAX;
        end
        else
        begin
            eff_height = height_reg;
        end
    end

    // Handshakes and queue credit: every pixel in flight may still add four results.
    assign inflight    = 3'(a1_valid_reg) + 3'(status.b_valid) + 3'(status.c_valid);
    assign credit_used = CRED_W'(fifo_count) + CRED_W'({inflight, 2'b00});
    assign in_stall    = credit_used > CRED_W'(FIFO_DEPTH - SLOTS);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = fifo_count != '0;
    assign pop         = out_valid && !out_stall;
    assign dims_write  = cfg_write && (cfg_index == REG_IMAGE_WIDTH
                                       || cfg_index == REG_IMAGE_HEIGHT);

    assign last_col = (13'(col_count_reg) + 13'd1) >= 13'(eff_width);
    assign last_row = (13'(row_count_reg) + 13'd1) >= eff_height;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            blur_reg   <= 1'b1;
            decim_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:     width_reg  <= cfg_data[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT:    height_reg <= cfg_data[HEIGHT_BITS-1:0];
                REG_BLUR_ENABLE:     blur_reg   <= cfg_data[0];
                REG_DECIMATE_ENABLE: decim_reg  <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Raster position of the next pixel.
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (dims_write)
        begin
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_count_next = '0;
                row_count_next = last_row ? 12'd0 : row_count_reg + 12'd1;
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // Results this pixel releases: the row above and, on the last row, this row;
    // each at the previous column and, at the row end, at the right edge.
    always_comb
    begin
        logic [11:0]      slot_x [SLOTS];
        logic [11:0]      slot_y [SLOTS];
        logic [SLOTS-1:0] slot_en;
        logic [2:0][1:0]  rows_above;
        logic [2:0][1:0]  rows_here;
        logic [2:0][1:0]  cols_prev;
        logic [2:0][1:0]  cols_edge;
        logic [11:0]      ox;
        logic [11:0]      oy;

        rows_above = {SEL_2, SEL_1, (row_count_reg == 12'd1) ? SEL_1 : SEL_0};
        rows_here  = {SEL_2, SEL_2, (row_count_reg == 12'd0) ? SEL_2 : SEL_1};
        cols_prev  = {SEL_2, SEL_1, (col_count_reg == COL_W'(1)) ? SEL_1 : SEL_0};
        cols_edge  = {SEL_2, SEL_2, (eff_width == 12'd1) ? SEL_2 : SEL_1};

        slot_x[0] = 12'(col_count_reg) - 12'd1;
        slot_x[1] = eff_width - 12'd1;
        slot_x[2] = slot_x[0];
        slot_x[3] = slot_x[1];
        slot_y[0] = row_count_reg - 12'd1;
        slot_y[1] = slot_y[0];
        slot_y[2] = row_count_reg;
        slot_y[3] = row_count_reg;
        slot_en[0] = (row_count_reg != 12'd0) && (col_count_reg != '0);
        slot_en[1] = (row_count_reg != 12'd0) && last_col;
        slot_en[2] = last_row && (col_count_reg != '0);
        slot_en[3] = last_row && last_col;

        meta_now[0].rsel = rows_above;
        meta_now[1].rsel = rows_above;
        meta_now[2].rsel = rows_here;
        meta_now[3].rsel = rows_here;
        meta_now[0].csel = cols_prev;
        meta_now[1].csel = cols_edge;
        meta_now[2].csel = cols_prev;
        meta_now[3].csel = cols_edge;

        for (int k = 0; k < SLOTS; k++)
        begin
            if (decim_reg)
            begin
                ox = slot_x[k] >> 1;
                oy = slot_y[k] >> 1;
                meta_now[k].keep = slot_en[k] && !slot_x[k][0] && !slot_y[k][0]
                    && ((13'(slot_y[k]) + 13'd1) < eff_height)
                    && ((13'(slot_x[k]) + 13'd1) < 13'(eff_width));
                meta_now[k].last = (13'(oy) == (eff_height >> 1) - 13'd1)
                    && (ox == (eff_width >> 1) - 12'd1);
            end
            else
            begin
                ox = slot_x[k];
                oy = slot_y[k];
                meta_now[k].keep = slot_en[k];
                meta_now[k].last = (13'(slot_y[k]) == eff_height - 13'd1)
                    && (slot_x[k] == eff_width - 12'd1);
            end
            meta_now[k].col = ox[10:0];
            meta_now[k].row = oy;
        end
    end

    // Line store: read at the pixel's column, written back in the cycle after.
    assign rd_addr = ADDR_W'(col_count_reg);
    assign fwd_hit = a1_valid_reg && (a1_addr_reg == rd_addr);

    bbd_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (a1_valid_reg),
        .wr_addr (a1_addr_reg),
        .wr_data (line_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (mem_rd_data)
    );

    // Forwarded word wins over the memory when the previous pixel hit the same column.
    assign line_word    = a1_fwd_reg ? a1_fwd_data_reg : mem_rd_data;
    assign line_wr_data = {line_word[7:0], a1_pixel_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_valid_reg <= 1'b0;
            a1_fwd_reg   <= 1'b0;
        end
        else
        begin
            a1_valid_reg <= accept;
            a1_fwd_reg   <= accept && fwd_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a1_pixel_reg    <= pixel_in;
            a1_addr_reg     <= rd_addr;
            a1_fwd_data_reg <= line_wr_data;
            a1_meta_reg     <= meta_now;
        end
    end

    // Window and arithmetic.
    assign win_in.valid = a1_valid_reg;
    assign win_in.pixel = a1_pixel_reg;
    assign win_in.up    = line_word[15:8];
    assign win_in.mid   = line_word[7:0];
    assign win_in.meta  = a1_meta_reg;

    bbd_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .win_in      (win_in),
        .blur_enable (blur_reg),
        .push_valid  (push_valid),
        .push_data   (push_data),
        .status      (status)
    );

    // Output queue.
    bbd_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .count      (fifo_count)
    );

    assign pixel_out  = head.pixel;
    assign out_col    = head.col;
    assign out_row    = head.row;
    assign frame_last = head.last;

    // The queue plus the results reserved for pixels in flight never exceed its depth.
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= CRED_W'(FIFO_DEPTH))
        else $error("result queue credit exceeded");

    // A forwarded line word always comes from a write-back in the cycle before.
    a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
        a1_fwd_reg |-> (a1_valid_reg && $past(a1_valid_reg)))
        else $error("forwarding without a preceding write-back");

    // The raster position stays inside the effective frame.
    a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (13'(col_count_reg) < 13'(eff_width)) && (13'(row_count_reg) < eff_height))
        else $error("raster position outside the frame");

endmodule

>>> hw/rtl/bbd_line_mem.sv
// Line store memory: older and newer row packed into one word, registered read.
module bbd_line_mem #(
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [15:0]              wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [15:0]              rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; returns the old word on a same-address write.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/bbd_window.sv
// 3x3 window registers, neighborhood sums and the divide by nine.
module bbd_window
    import bbd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  win_in_t                 win_in,
    input  logic                    blur_enable,
    output logic [SLOTS-1:0]        push_valid,
    output result_t [SLOTS-1:0]     push_data,
    output pipe_status_t            status
);

    logic [2:0][2:0][7:0]   window_reg;
    logic                   b_valid_reg;
    slot_meta_t [SLOTS-1:0] b_meta_reg;
    logic                   c_valid_reg;
    logic [SLOTS-1:0]       c_keep_reg;
    logic [11:0]            c_sum_reg    [SLOTS];
    logic [7:0]             c_centre_reg [SLOTS];
    logic [10:0]            c_col_reg    [SLOTS];
    logic [11:0]            c_row_reg    [SLOTS];
    logic [SLOTS-1:0]       c_last_reg;

    logic [11:0]            sum_next    [SLOTS];
    logic [7:0]             centre_next [SLOTS];
    logic [24:0]            prod        [SLOTS];

    // Shift the window one column and load the new column from the line store word and the incoming pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (win_in.valid)
        begin
            for (int i = 0; i < 3; i++)
            begin
                window_reg[i][0] <= window_reg[i][1];
                window_reg[i][1] <= window_reg[i][2];
            end
            window_reg[0][2] <= win_in.up;
            window_reg[1][2] <= win_in.mid;
            window_reg[2][2] <= win_in.pixel;
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= win_in.valid;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Sum the selected rows per column, then the selected columns.
    always_comb
    begin
        logic [9:0] colsum [3];
        for (int k = 0; k < SLOTS; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                colsum[j] = 10'(window_reg[b_meta_reg[k].rsel[0]][j])
                          + 10'(window_reg[b_meta_reg[k].rsel[1]][j])
                          + 10'(window_reg[b_meta_reg[k].rsel[2]][j]);
            end
            sum_next[k] = 12'(colsum[b_meta_reg[k].csel[0]])
                        + 12'(colsum[b_meta_reg[k].csel[1]])
                        + 12'(colsum[b_meta_reg[k].csel[2]]);
            centre_next[k] = window_reg[b_meta_reg[k].rsel[1]][b_meta_reg[k].csel[1]];
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        b_meta_reg <= win_in.meta;
        for (int k = 0; k < SLOTS; k++)
        begin
            c_keep_reg[k]   <= b_meta_reg[k].keep;
            c_sum_reg[k]    <= sum_next[k];
            c_centre_reg[k] <= centre_next[k];
            c_col_reg[k]    <= b_meta_reg[k].col;
            c_row_reg[k]    <= b_meta_reg[k].row;
            c_last_reg[k]   <= b_meta_reg[k].last;
        end
    end

    // Divide by nine through the reciprocal and choose mean or center pixel.
    always_comb
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            prod[k]             = 25'(c_sum_reg[k]) * 25'(DIV9_RECIP);
            push_valid[k]       = c_valid_reg && c_keep_reg[k];
            push_data[k].pixel  = blur_enable ? prod[k][23:16] : c_centre_reg[k];
            push_data[k].col    = c_col_reg[k];
            push_data[k].row    = c_row_reg[k];
            push_data[k].last   = c_last_reg[k];
        end
    end

    assign status.b_valid = b_valid_reg;
    assign status.c_valid = c_valid_reg;

endmodule

>>> hw/rtl/bbd_result_fifo.sv
// Result queue: takes up to four results a cycle, hands out one.
module bbd_result_fifo
    import bbd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SLOTS-1:0]    push_valid,
    input  result_t [SLOTS-1:0] push_data,
    input  logic                pop,
    output result_t             head,
    output logic [CNT_W-1:0]    count
);

    result_t          queue_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [2:0]       offset [SLOTS];
    logic [PTR_W-1:0] wr_idx [SLOTS];
    logic [2:0]       pushed;

    // Pack the valid results next to each other behind the write pointer.
    always_comb
    begin
        offset[0] = 3'd0;
        for (int k = 1; k < SLOTS; k++)
        begin
            offset[k] = offset[k-1] + 3'(push_valid[k-1]);
        end
        pushed = offset[SLOTS-1] + 3'(push_valid[SLOTS-1]);
        for (int k = 0; k < SLOTS; k++)
        begin
            wr_idx[k] = wr_ptr_reg + PTR_W'(offset[k]);
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            if (push_valid[k])
            begin
                queue_reg[wr_idx[k]] <= push_data[k];
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(pushed);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(pushed) - CNT_W'(pop);
        end
    end

    assign head  = queue_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule
